// File: rtl/msba_pkg.sv
// ----------------------------------------------------------------------------
// msba_pkg
// Shared types, constants and helpers for the multichannel sensor block
// averager: payload structs, config register map, controller commands.
// ----------------------------------------------------------------------------
package msba_pkg;

  localparam int MaxChannels = 8;
  localparam int SampleBits  = 12;
  localparam int AddrW       = 4;
  localparam int DataW       = 32;
  localparam int SumW        = 16;
  localparam int LenW        = 8;
  localparam int TotalW      = 11;
  localparam int RecipW      = 17;
  localparam int RecipShift  = 16;

  typedef enum logic [1:0] {
    RegGain      = 2'd0,
    RegOffset    = 2'd1,
    RegAvgLen    = 2'd2,
    RegChanCount = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  channel;
    logic [11:0] sample;
    logic        round_end;
  } in_t;

  typedef struct packed {
    logic [2:0] out_channel;
    logic [7:0] percent;
    logic       avg_valid;
    logic [7:0] avg_percent;
    logic       round_done;
    logic [7:0] mean_last;
    logic [7:0] mean_avg;
  } out_t;

  typedef struct packed {
    logic signed [23:0] gain_q16;
    logic signed [31:0] offset_q16;
    logic [LenW-1:0]    avg_len;
    logic [3:0]         channel_count;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic cal;
    logic div_start;
    logic div_wr;
    logic sweep_step;
    logic mean;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic avg_round;
    logic rend;
    logic div_done;
    logic sweep_last;
  } status_t;

  // ceil(2^16 / c): exact floor division for totals below 2^11, c in 1..8
  function automatic logic [RecipW-1:0] recip(input logic [3:0] c);
    logic [RecipW-1:0] r;
    case (c)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/msba_regs.sv
// ----------------------------------------------------------------------------
// msba_regs
// APB-style configuration registers: gain, offset, average length and
// channel count. Zero wait states.
// ----------------------------------------------------------------------------
module msba_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msba_pkg::AddrW-1:0]  paddr,
  input  logic [msba_pkg::DataW-1:0]  pwdata,
  output logic [msba_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output msba_pkg::cfg_t              cfg_o
);

  msba_pkg::cfg_t     cfg_q;
  msba_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = msba_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_q16      <= '0;
      cfg_q.offset_q16    <= '0;
      cfg_q.avg_len       <= 8'd1;
      cfg_q.channel_count <= 4'd1;
    end else if (wr_en) begin
      case (idx)
        msba_pkg::RegGain:      cfg_q.gain_q16      <= pwdata[23:0];
        msba_pkg::RegOffset:    cfg_q.offset_q16    <= pwdata;
        msba_pkg::RegAvgLen:    cfg_q.avg_len       <= pwdata[7:0];
        msba_pkg::RegChanCount: cfg_q.channel_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      msba_pkg::RegGain:      prdata = {8'd0, cfg_q.gain_q16};
      msba_pkg::RegOffset:    prdata = cfg_q.offset_q16;
      msba_pkg::RegAvgLen:    prdata = {24'd0, cfg_q.avg_len};
      msba_pkg::RegChanCount: prdata = {28'd0, cfg_q.channel_count};
      default:                prdata = '0;
    endcase
  end

endmodule

// File: rtl/msba_div.sv
// ----------------------------------------------------------------------------
// msba_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit
// per cycle. done_o pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module msba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msba_pkg::SumW-1:0]  dividend_i,
  input  logic [msba_pkg::LenW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [msba_pkg::SumW-1:0]  quotient_o
);

  localparam int CntW = $clog2(msba_pkg::SumW + 1);

  logic [msba_pkg::SumW-1:0] dvd_q;
  logic [msba_pkg::LenW-1:0] rem_q;
  logic [msba_pkg::LenW-1:0] dvs_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [msba_pkg::LenW:0]   shifted;
  logic                      fits;

  assign shifted    = {rem_q, dvd_q[msba_pkg::SumW-1]};
  assign fits       = shifted >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(msba_pkg::SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[msba_pkg::SumW-2:0], fits};
      rem_q <= fits ? msba_pkg::LenW'(shifted - {1'b0, dvs_q})
                    : shifted[msba_pkg::LenW-1:0];
    end
  end

endmodule

// File: rtl/msba_dp.sv
// ----------------------------------------------------------------------------
// msba_dp
// Datapath: calibration multiply and clamp, per-channel stores, block
// average divide, channel sweep for the means, output register.
// ----------------------------------------------------------------------------
module msba_dp #(
  parameter int MAX_CHANNELS = msba_pkg::MaxChannels,
  parameter int SAMPLE_BITS  = msba_pkg::SampleBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msba_pkg::cfg_t    cfg_i,
  input  msba_pkg::in_t     in_data_i,
  input  msba_pkg::cmd_t    cmd_i,
  output msba_pkg::status_t st_o,
  output msba_pkg::out_t    out_data_o
);

  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CodeW = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;
  localparam int ProdW = 24 + CodeW + 1;
  localparam int VW    = ProdW + 1;
  localparam int MeanW = msba_pkg::TotalW + msba_pkg::RecipW;
  localparam logic [3:0] MaxCnt = 4'(MAX_CHANNELS);

  // state
  logic [7:0]                lv_q  [MAX_CHANNELS];
  logic [msba_pkg::SumW-1:0] sum_q [MAX_CHANNELS];
  logic [7:0]                avg_q [MAX_CHANNELS];
  logic [7:0]                round_count_q;
  logic [msba_pkg::TotalW-1:0] tl_q, ta_q;

  // working registers
  msba_pkg::in_t             item_q;
  logic [ChW-1:0]            ch_q;
  logic signed [ProdW-1:0]   prod_q;
  logic [7:0]                pct_q;
  logic [7:0]                avg_pct_q;
  logic                      avg_valid_q;
  logic [7:0]                mean_l_q, mean_a_q;
  logic [ChW-1:0]            sweep_idx_q;
  msba_pkg::out_t            out_q;

  logic [msba_pkg::LenW-1:0] len_eff;
  logic [3:0]                cnt_eff;
  logic [2:0]                ch_masked;
  logic [CodeW-1:0]          code;
  logic signed [VW-1:0]      v;
  logic [7:0]                pct;
  logic [msba_pkg::SumW:0]   sum_raw;
  logic [msba_pkg::SumW-1:0] sum_sat;
  logic [ChW-1:0]            rd_idx;
  logic                      in_mean;
  logic [MeanW-1:0]          ml_prod, ma_prod;
  logic                      div_done;
  logic [msba_pkg::SumW-1:0] quot;
  logic [7:0]                quot_sat;

  assign len_eff   = (cfg_i.avg_len == '0) ? 8'd1 : cfg_i.avg_len;
  assign cnt_eff   = (cfg_i.channel_count == 4'd0)  ? 4'd1 :
                     (cfg_i.channel_count > MaxCnt) ? MaxCnt : cfg_i.channel_count;
  assign ch_masked = in_data_i.channel & 3'(MAX_CHANNELS - 1);
  assign code      = item_q.sample[CodeW-1:0];

  // calibration: floor((gain*code + offset) / 2^16), clamped to 0..255
  assign v = VW'(prod_q) + VW'(cfg_i.offset_q16);
  always_comb begin
    if (v[VW-1])             pct = 8'd0;
    else if (|v[VW-2:24])    pct = 8'd255;
    else                     pct = v[23:16];
  end

  assign sum_raw = {1'b0, sum_q[ch_q]} + {9'd0, pct};
  assign sum_sat = sum_raw[msba_pkg::SumW] ? '1 : sum_raw[msba_pkg::SumW-1:0];
  assign rd_idx  = cmd_i.sweep_step ? sweep_idx_q : ch_q;
  assign in_mean = {{(4 - ChW){1'b0}}, sweep_idx_q} < cnt_eff;

  assign ml_prod  = MeanW'(tl_q) * MeanW'(msba_pkg::recip(cnt_eff));
  assign ma_prod  = MeanW'(ta_q) * MeanW'(msba_pkg::recip(cnt_eff));
  assign quot_sat = (|quot[msba_pkg::SumW-1:8]) ? 8'd255 : quot[7:0];

  msba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_sat),
    .divisor_i  (len_eff),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign st_o.avg_round  = ({1'b0, round_count_q} + 9'd1) >= {1'b0, len_eff};
  assign st_o.rend       = item_q.round_end;
  assign st_o.div_done   = div_done;
  assign st_o.sweep_last = sweep_idx_q == ChW'(MAX_CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        lv_q[i]  <= '0;
        sum_q[i] <= '0;
        avg_q[i] <= '0;
      end
      round_count_q <= '0;
      tl_q          <= '0;
      ta_q          <= '0;
    end else begin
      if (cmd_i.cal) begin
        lv_q[ch_q] <= pct;
        if (!st_o.avg_round) sum_q[ch_q] <= sum_sat;
        tl_q <= '0;
        ta_q <= '0;
      end
      if (cmd_i.div_wr) begin
        avg_q[ch_q] <= quot_sat;
        sum_q[ch_q] <= '0;
      end
      if (cmd_i.sweep_step && in_mean) begin
        tl_q <= tl_q + msba_pkg::TotalW'(lv_q[rd_idx]);
        ta_q <= ta_q + msba_pkg::TotalW'(avg_q[rd_idx]);
      end
      if (cmd_i.mean) begin
        round_count_q <= st_o.avg_round ? 8'd0 : round_count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
      ch_q   <= ch_masked[ChW-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(cfg_i.gain_q16) * $signed({1'b0, code});
    end
    // round counter may move before the result is loaded
    if (cmd_i.cal) begin
      pct_q       <= pct;
      avg_pct_q   <= avg_q[rd_idx];
      avg_valid_q <= st_o.avg_round;
      sweep_idx_q <= '0;
    end
    if (cmd_i.div_wr) avg_pct_q <= quot_sat;
    if (cmd_i.sweep_step) sweep_idx_q <= sweep_idx_q + 1'b1;
    if (cmd_i.mean) begin
      mean_l_q <= (|ml_prod[MeanW-1:24]) ? 8'd255 : ml_prod[23:16];
      mean_a_q <= (|ma_prod[MeanW-1:24]) ? 8'd255 : ma_prod[23:16];
    end
    if (cmd_i.out_load) begin
      out_q.out_channel <= 3'(ch_q);
      out_q.percent     <= pct_q;
      out_q.avg_valid   <= avg_valid_q;
      out_q.avg_percent <= avg_pct_q;
      out_q.round_done  <= item_q.round_end;
      out_q.mean_last   <= item_q.round_end ? mean_l_q : 8'd0;
      out_q.mean_avg    <= item_q.round_end ? mean_a_q : 8'd0;
    end
  end

  assign out_data_o = out_q;

  // a round that averaged must leave the round counter cleared
  a_round_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mean && st_o.avg_round |=> round_count_q == 8'd0)
    else $error("round counter not cleared after averaging round");

endmodule

// File: rtl/msba_ctrl.sv
// ----------------------------------------------------------------------------
// msba_ctrl
// Controller: one item goes through multiply, calibrate, divide on averaging
// rounds, channel sweep and mean on round ends, then to the output register.
// ----------------------------------------------------------------------------
module msba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  msba_pkg::status_t st_i,
  output msba_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CAL,
    S_DIV,
    S_SWEEP,
    S_MEAN,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul        = state_q == S_MUL;
    cmd_o.cal        = state_q == S_CAL;
    cmd_o.div_start  = (state_q == S_CAL) && st_i.avg_round;
    cmd_o.div_wr     = (state_q == S_DIV) && st_i.div_done;
    cmd_o.sweep_step = state_q == S_SWEEP;
    cmd_o.mean       = state_q == S_MEAN;
    cmd_o.out_load   = (state_q == S_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load)    out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_CAL;
        S_CAL: begin
          if (st_i.avg_round) state_q <= S_DIV;
          else if (st_i.rend) state_q <= S_SWEEP;
          else                state_q <= S_FIN;
        end
        S_DIV: begin
          if (st_i.div_done) state_q <= st_i.rend ? S_SWEEP : S_FIN;
        end
        S_SWEEP: begin
          if (st_i.sweep_last) state_q <= S_MEAN;
        end
        S_MEAN: state_q <= S_FIN;
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

  a_sweep_on_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> st_i.rend)
    else $error("channel sweep on an item that does not end a round");

  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MUL)
    else $error("accepted item did not enter multiply");

endmodule

// File: rtl/multichannel_sensor_block_averager.sv
// ----------------------------------------------------------------------------
// multichannel_sensor_block_averager
// Per-channel linear calibration of ADC codes with block averages and
// cross-channel means at each round end.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  msba_pkg::in_t  (channel, sample, round_end)
//  out      out  out_valid_o/out_stall_i msba_pkg::out_t (one result per item)
//  cfg      in   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item at a time: it is accepted, multiplied, calibrated and output;
// an averaging round adds a pass through the shift/subtract divider, and a
// round end adds a sweep over every channel slot followed by the means.
// Reset clears all channel stores and the round counter, and returns the
// config registers to their defaults.
// A stalled result sits in the output register while the next item is accepted.
module multichannel_sensor_block_averager #(
  parameter int MAX_CHANNELS = msba_pkg::MaxChannels,
  parameter int SAMPLE_BITS  = msba_pkg::SampleBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  msba_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output msba_pkg::out_t             out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msba_pkg::AddrW-1:0] paddr,
  input  logic [msba_pkg::DataW-1:0] pwdata,
  output logic [msba_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  msba_pkg::cfg_t    cfg;
  msba_pkg::cmd_t    cmd;
  msba_pkg::status_t st;

  msba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  msba_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

endmodule
